// File: rtl/cacl_pkg.sv
// ----------------------------------------------------------------------------
// cacl_pkg
// Types and constants shared by the connection ACL classifier modules.
// ----------------------------------------------------------------------------
package cacl_pkg;

   localparam logic [2:0] CMD_CHECK      = 3'd0;
   localparam logic [2:0] CMD_WR_RULE    = 3'd1;
   localparam logic [2:0] CMD_CLR_RULE   = 3'd2;
   localparam logic [2:0] CMD_WR_POLICY  = 3'd3;
   localparam logic [2:0] CMD_CLR_POLICY = 3'd4;

   localparam logic [3:0]  STYPE_STREAM   = 4'd1;
   localparam logic [3:0]  STYPE_DATAGRAM = 4'd2;
   localparam logic [7:0]  PROTO_TCP   = 8'd6;
   localparam logic [7:0]  PROTO_UDP   = 8'd17;
   localparam logic [31:0] PROTO_MAX   = 32'd255;

   localparam logic [1:0] LEVEL_OPEN    = 2'd0;
   localparam logic [1:0] LEVEL_DEFAULT = 2'd1;
   localparam logic [1:0] LEVEL_LOCKED  = 2'd2;

   localparam logic [1:0] CAUSE_NONE     = 2'd0;
   localparam logic [1:0] CAUSE_LOCKED   = 2'd1;
   localparam logic [1:0] CAUSE_DENY_HIT = 2'd2;
   localparam logic [1:0] CAUSE_NO_ALLOW = 2'd3;

   localparam logic [7:0] PLEN_V4 = 8'd32;
   localparam logic [7:0] PLEN_V6 = 8'd128;

   localparam int REQ_DATA_W = 272;
   localparam int RSP_DATA_W = 16;

   typedef struct packed {
      logic [2:0]  command;
      logic [5:0]  slot;
      logic [63:0] group_id;
      logic        is_ipv6;
      logic [31:0] sock_protocol;
      logic [3:0]  sock_type;
      logic [15:0] port;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [7:0]  prefix_len;
      logic        rule_is_deny;
      logic [7:0]  policy_value;
   } req_type;

   typedef struct packed {
      logic        allowed;
      logic [1:0]  deny_cause;
      logic [7:0]  effective_protocol;
      logic [1:0]  policy_level;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  prefix_len;
      logic [15:0] port;
      logic [7:0]  protocol;
      logic        is_ipv6;
      logic        deny;
      logic        valid;
   } rule_meta_type;

   typedef struct packed {
      logic [63:0] group_id;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
   } rule_data_type;

   typedef struct packed {
      logic [1:0] level;
      logic       valid;
   } policy_entry_type;

   typedef struct packed {
      logic load;
      logic sweep_wr;
      logic exec_wr;
      logic idx_clear;
      logic idx_inc;
      logic pol_rd;
      logic rule_rd;
      logic out_load;
   } ctl_type;

   typedef struct packed {
      logic in_is_check;
      logic sweep_last;
      logic pol_last;
      logic rule_last;
   } sts_type;

endpackage

// File: rtl/cacl_dp.sv
// ----------------------------------------------------------------------------
// cacl_dp
// Datapath: request register, rule and policy memories, scan compare and
// result register.
// ----------------------------------------------------------------------------
module cacl_dp #(
   parameter int RULE_SLOTS   = 64,
   parameter int POLICY_SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  cacl_pkg::req_type req,
   input  cacl_pkg::ctl_type ctl,
   output cacl_pkg::sts_type sts,
   output cacl_pkg::rsp_type rsp
);

   localparam int RIDX_W = $clog2(RULE_SLOTS);
   localparam int PIDX_W = (POLICY_SLOTS > 1) ? $clog2(POLICY_SLOTS) : 1;
   localparam int MAX_SLOTS = (RULE_SLOTS > POLICY_SLOTS) ? RULE_SLOTS : POLICY_SLOTS;
   localparam int CNT_W = $clog2(MAX_SLOTS);

   cacl_pkg::rule_meta_type    rule_meta_mem [RULE_SLOTS];
   cacl_pkg::rule_data_type    rule_data_mem [RULE_SLOTS];
   cacl_pkg::policy_entry_type policy_mem    [POLICY_SLOTS];
   logic [63:0]                policy_grp_mem[POLICY_SLOTS];

   cacl_pkg::req_type          req_ff, req_in;
   logic [CNT_W-1:0]           idx_ff;
   cacl_pkg::rule_meta_type    meta_q_ff;
   cacl_pkg::rule_data_type    data_q_ff;
   cacl_pkg::policy_entry_type pent_q_ff;
   logic [63:0]                pgrp_q_ff;
   logic                       pol_vld_ff, rule_vld_ff;
   logic                       found_ff, deny_hit_ff, allow_hit_ff;
   logic [1:0]                 lvl_ff;
   cacl_pkg::rsp_type          rsp_ff, rsp_in;

   logic                       rule_slot_ok, pol_slot_ok;
   logic                       sweep_rule, sweep_pol;
   logic [RIDX_W-1:0]          rule_waddr;
   logic [PIDX_W-1:0]          pol_waddr;
   logic [127:0]               mask6;
   logic [31:0]                mask4;
   logic                       addr_ok, rule_hit;
   logic [7:0]                 eff_proto, wr_proto, max_plen;
   logic [1:0]                 cause, wr_level;

   assign sts.in_is_check = (req.command == cacl_pkg::CMD_CHECK);
   assign sts.sweep_last  = (idx_ff == CNT_W'(MAX_SLOTS - 1));
   assign sts.pol_last    = (idx_ff == CNT_W'(POLICY_SLOTS - 1));
   assign sts.rule_last   = (idx_ff == CNT_W'(RULE_SLOTS - 1));

   // request capture: protocol fallback and range check, v4 address masking, prefix saturation
   always_comb begin
      req_in = req;
      wr_proto = (req.sock_protocol > cacl_pkg::PROTO_MAX) ? 8'd0 : req.sock_protocol[7:0];
      if (req.sock_protocol == 32'd0) begin
         if (req.sock_type == cacl_pkg::STYPE_STREAM) begin
            eff_proto = cacl_pkg::PROTO_TCP;
         end else if (req.sock_type == cacl_pkg::STYPE_DATAGRAM) begin
            eff_proto = cacl_pkg::PROTO_UDP;
         end else begin
            eff_proto = 8'd0;
         end
      end else begin
         eff_proto = wr_proto;
      end
      req_in.sock_protocol = {24'd0,
         (req.command == cacl_pkg::CMD_CHECK) ? eff_proto : wr_proto};
      if (!req.is_ipv6) begin
         req_in.addr_high = 64'd0;
         req_in.addr_low  = {32'd0, req.addr_low[31:0]};
      end
      max_plen = req.is_ipv6 ? cacl_pkg::PLEN_V6 : cacl_pkg::PLEN_V4;
      if (req.prefix_len > max_plen) begin
         req_in.prefix_len = max_plen;
      end
   end

   assign rule_slot_ok = (32'(req_ff.slot) < RULE_SLOTS);
   assign pol_slot_ok  = (32'(req_ff.slot) < POLICY_SLOTS);
   assign sweep_rule   = ({1'b0, idx_ff} < (CNT_W + 1)'(RULE_SLOTS));
   assign sweep_pol    = ({1'b0, idx_ff} < (CNT_W + 1)'(POLICY_SLOTS));
   assign rule_waddr   = RIDX_W'(req_ff.slot);
   assign pol_waddr    = PIDX_W'(req_ff.slot);
   assign wr_level     = (req_ff.policy_value > 8'(cacl_pkg::LEVEL_LOCKED)) ?
                         cacl_pkg::LEVEL_LOCKED : req_ff.policy_value[1:0];

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (ctl.idx_clear) begin
         idx_ff <= '0;
      end else if (ctl.idx_inc) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end
   end

   // rule memories
   always_ff @(posedge clock) begin
      if (ctl.sweep_wr && sweep_rule) begin
         rule_meta_mem[idx_ff[RIDX_W-1:0]] <= '0;
      end else if (ctl.exec_wr && rule_slot_ok &&
                   req_ff.command == cacl_pkg::CMD_WR_RULE) begin
         rule_meta_mem[rule_waddr] <= '{prefix_len: req_ff.prefix_len,
                                        port:       req_ff.port,
                                        protocol:   req_ff.sock_protocol[7:0],
                                        is_ipv6:    req_ff.is_ipv6,
                                        deny:       req_ff.rule_is_deny,
                                        valid:      1'b1};
         rule_data_mem[rule_waddr] <= '{group_id:  req_ff.group_id,
                                        addr_high: req_ff.addr_high,
                                        addr_low:  req_ff.addr_low};
      end else if (ctl.exec_wr && rule_slot_ok &&
                   req_ff.command == cacl_pkg::CMD_CLR_RULE) begin
         rule_meta_mem[rule_waddr] <= '0;
      end
      if (ctl.rule_rd) begin
         meta_q_ff <= rule_meta_mem[idx_ff[RIDX_W-1:0]];
         data_q_ff <= rule_data_mem[idx_ff[RIDX_W-1:0]];
      end
   end

   // policy memories
   always_ff @(posedge clock) begin
      if (ctl.sweep_wr && sweep_pol) begin
         policy_mem[idx_ff[PIDX_W-1:0]] <= '0;
      end else if (ctl.exec_wr && pol_slot_ok &&
                   req_ff.command == cacl_pkg::CMD_WR_POLICY) begin
         policy_mem[pol_waddr]     <= '{level: wr_level, valid: 1'b1};
         policy_grp_mem[pol_waddr] <= req_ff.group_id;
      end else if (ctl.exec_wr && pol_slot_ok &&
                   req_ff.command == cacl_pkg::CMD_CLR_POLICY) begin
         policy_mem[pol_waddr] <= '0;
      end
      if (ctl.pol_rd) begin
         pent_q_ff <= policy_mem[idx_ff[PIDX_W-1:0]];
         pgrp_q_ff <= policy_grp_mem[idx_ff[PIDX_W-1:0]];
      end
   end

   // rule compare on registered read data
   always_comb begin
      mask6 = ~(~128'd0 >> meta_q_ff.prefix_len);
      mask4 = ~(~32'd0 >> meta_q_ff.prefix_len);
      if (req_ff.is_ipv6) begin
         addr_ok = ((({data_q_ff.addr_high, data_q_ff.addr_low}) ^
                     {req_ff.addr_high, req_ff.addr_low}) & mask6) == 128'd0;
      end else begin
         addr_ok = ((data_q_ff.addr_low[31:0] ^ req_ff.addr_low[31:0]) & mask4) == 32'd0;
      end
      rule_hit = meta_q_ff.valid && (meta_q_ff.is_ipv6 == req_ff.is_ipv6) &&
                 (data_q_ff.group_id == req_ff.group_id) &&
                 (meta_q_ff.protocol == 8'd0 ||
                  meta_q_ff.protocol == req_ff.sock_protocol[7:0]) &&
                 (meta_q_ff.port == 16'd0 || meta_q_ff.port == req_ff.port) &&
                 addr_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pol_vld_ff   <= 1'b0;
         rule_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         deny_hit_ff  <= 1'b0;
         allow_hit_ff <= 1'b0;
         lvl_ff       <= cacl_pkg::LEVEL_OPEN;
      end else begin
         pol_vld_ff  <= ctl.pol_rd;
         rule_vld_ff <= ctl.rule_rd;
         if (ctl.load) begin
            found_ff     <= 1'b0;
            deny_hit_ff  <= 1'b0;
            allow_hit_ff <= 1'b0;
            lvl_ff       <= cacl_pkg::LEVEL_OPEN;
         end else begin
            if (pol_vld_ff && !found_ff && pent_q_ff.valid &&
                pgrp_q_ff == req_ff.group_id) begin
               found_ff <= 1'b1;
               lvl_ff   <= pent_q_ff.level;
            end
            if (rule_vld_ff && rule_hit) begin
               if (meta_q_ff.deny) begin
                  deny_hit_ff <= 1'b1;
               end else begin
                  allow_hit_ff <= 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      if (lvl_ff == cacl_pkg::LEVEL_LOCKED) begin
         cause = cacl_pkg::CAUSE_LOCKED;
      end else if (deny_hit_ff) begin
         cause = cacl_pkg::CAUSE_DENY_HIT;
      end else if (lvl_ff == cacl_pkg::LEVEL_DEFAULT && !allow_hit_ff) begin
         cause = cacl_pkg::CAUSE_NO_ALLOW;
      end else begin
         cause = cacl_pkg::CAUSE_NONE;
      end
      rsp_in = '0;
      if (req_ff.command == cacl_pkg::CMD_CHECK) begin
         rsp_in.allowed            = (cause == cacl_pkg::CAUSE_NONE);
         rsp_in.deny_cause         = cause;
         rsp_in.effective_protocol = req_ff.sock_protocol[7:0];
         rsp_in.policy_level       = lvl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

// File: rtl/cacl_ctrl.sv
// ----------------------------------------------------------------------------
// cacl_ctrl
// Controller: clearing sweep, command sequencing, scans and result handoff.
// ----------------------------------------------------------------------------
module cacl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  cacl_pkg::sts_type sts,
   output cacl_pkg::ctl_type ctl
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_POL_SCAN,
      ST_RULE_SCAN,
      ST_RULE_WAIT,
      ST_RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            ctl.sweep_wr = 1'b1;
            ctl.idx_inc  = 1'b1;
            if (sts.sweep_last) begin
               ctl.idx_clear = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               ctl.load      = 1'b1;
               ctl.idx_clear = 1'b1;
               state_in      = sts.in_is_check ? ST_POL_SCAN : ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.exec_wr = 1'b1;
            state_in    = ST_RESPOND;
         end
         ST_POL_SCAN: begin
            ctl.pol_rd  = 1'b1;
            ctl.idx_inc = 1'b1;
            if (sts.pol_last) begin
               ctl.idx_clear = 1'b1;
               state_in      = ST_RULE_SCAN;
            end
         end
         ST_RULE_SCAN: begin
            ctl.rule_rd = 1'b1;
            ctl.idx_inc = 1'b1;
            if (sts.rule_last) begin
               ctl.idx_clear = 1'b1;
               state_in      = ST_RULE_WAIT;
            end
         end
         ST_RULE_WAIT: begin
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (out_free) begin
               ctl.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ctl.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// File: rtl/connection_acl_classifier_top.sv
// ----------------------------------------------------------------------------
// connection_acl_classifier_top
// Connection admission filter with a rule store and a group policy store.
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  req_tdata[271:0]
//   rsp_     out  rsp_tvalid/rsp_tready  rsp_tdata[15:0]
//
// A check runs the accept, a scan of the policy slots, then of the rule
// slots, one slot read from memory per cycle, a compare step and the result
// load. Write and clear items run the accept, the write and the result load.
// After reset a sweep clears rule and policy valid state before the first
// item is taken.
// The result register lets the next item enter while a result waits.
// ----------------------------------------------------------------------------
module connection_acl_classifier_top #(
   parameter int RULE_SLOTS   = 64,
   parameter int POLICY_SLOTS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command[2:0] slot[8:3] group_id[72:9] is_ipv6[73] sock_protocol[105:74]
   // sock_type[109:106] port[125:110] addr_high[189:126] addr_low[253:190]
   // prefix_len[261:254] rule_is_deny[262] policy_value[270:263] pad[271]
   input  logic [271:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // allowed[0] deny_cause[2:1] effective_protocol[10:3] policy_level[12:11]
   output logic [15:0]  rsp_tdata
);

   cacl_pkg::req_type req;
   cacl_pkg::rsp_type rsp;
   cacl_pkg::ctl_type ctl;
   cacl_pkg::sts_type sts;

   assign req.command       = req_tdata[2:0];
   assign req.slot          = req_tdata[8:3];
   assign req.group_id      = req_tdata[72:9];
   assign req.is_ipv6       = req_tdata[73];
   assign req.sock_protocol = req_tdata[105:74];
   assign req.sock_type     = req_tdata[109:106];
   assign req.port          = req_tdata[125:110];
   assign req.addr_high     = req_tdata[189:126];
   assign req.addr_low      = req_tdata[253:190];
   assign req.prefix_len    = req_tdata[261:254];
   assign req.rule_is_deny  = req_tdata[262];
   assign req.policy_value  = req_tdata[270:263];

   assign rsp_tdata = {3'd0, rsp.policy_level, rsp.effective_protocol,
                       rsp.deny_cause, rsp.allowed};

   cacl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   cacl_dp #(
      .RULE_SLOTS   (RULE_SLOTS),
      .POLICY_SLOTS (POLICY_SLOTS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .ctl   (ctl),
      .sts   (sts),
      .rsp   (rsp)
   );

endmodule

// File: dv/connection_acl_classifier_top_test.sv
// ----------------------------------------------------------------------------
// connection_acl_classifier_top_test
// Self-checking bench for the connection ACL classifier. Directed items walk
// the policy levels, rule kinds, protocol fallback, prefix handling and
// ignored slots. Random rule, policy and check traffic follows, built around
// a small pool of groups and addresses so that checks hit stored rules. Each
// result is compared with an in-bench predictor of the rule and policy stores.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module connection_acl_classifier_top_test;

   localparam int NUM_RULES    = 64;
   localparam int NUM_POLICIES = 16;
   localparam int STALL_LIMIT  = 20000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [271:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [15:0]  rsp_tdata;

   connection_acl_classifier_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // rule and policy store copy
   logic        acl_valid  [NUM_RULES];
   logic        acl_deny   [NUM_RULES];
   logic        acl_v6     [NUM_RULES];
   logic [7:0]  acl_proto  [NUM_RULES];
   logic [15:0] acl_port   [NUM_RULES];
   logic [7:0]  acl_plen   [NUM_RULES];
   logic [63:0] acl_group  [NUM_RULES];
   logic [127:0] acl_addr  [NUM_RULES];
   logic        pol_valid  [NUM_POLICIES];
   logic [1:0]  pol_level  [NUM_POLICIES];
   logic [63:0] pol_group  [NUM_POLICIES];

   cacl_pkg::rsp_type verdict_q[$];
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int errors = 0;
   int stall_cycles = 0;
   int n_checks = 0, n_allowed = 0, n_locked = 0, n_deny_hit = 0, n_no_allow = 0;

   logic [63:0] grp_pool  [4];
   logic [127:0] addr_pool [4];

   function automatic logic rule_hits(int i, logic want_deny, logic [63:0] grp,
                                      logic v6, logic [7:0] proto,
                                      logic [15:0] port, logic [127:0] addr);
      logic [127:0] mask;
      if (!acl_valid[i] || acl_deny[i] != want_deny || acl_v6[i] != v6) return 1'b0;
      if (acl_group[i] != grp) return 1'b0;
      if (acl_proto[i] != 8'd0 && acl_proto[i] != proto) return 1'b0;
      if (acl_port[i] != 16'd0 && acl_port[i] != port) return 1'b0;
      if (v6) mask = (acl_plen[i] == 0) ? '0 : ~128'd0 << (128 - acl_plen[i]);
      else mask = (acl_plen[i] == 0) ? '0 : {96'd0, ~32'd0 << (32 - acl_plen[i])};
      return ((acl_addr[i] ^ addr) & mask) == '0;
   endfunction

   function automatic cacl_pkg::rsp_type classify(cacl_pkg::req_type r);
      cacl_pkg::rsp_type v;
      logic [127:0] addr;
      logic deny_hit, allow_hit;
      logic found;
      logic [7:0] plen;
      v = '0;
      case (r.command)
         cacl_pkg::CMD_CHECK: begin
            if (r.sock_protocol == 32'd0)
               v.effective_protocol =
                  (r.sock_type == cacl_pkg::STYPE_STREAM) ? cacl_pkg::PROTO_TCP :
                  (r.sock_type == cacl_pkg::STYPE_DATAGRAM) ? cacl_pkg::PROTO_UDP : 8'd0;
            else
               v.effective_protocol = (r.sock_protocol > cacl_pkg::PROTO_MAX) ? 8'd0 :
                                      r.sock_protocol[7:0];
            addr = r.is_ipv6 ? {r.addr_high, r.addr_low} : {96'd0, r.addr_low[31:0]};
            v.policy_level = cacl_pkg::LEVEL_OPEN;
            found = 1'b0;
            for (int p = 0; p < NUM_POLICIES; p++)
               if (!found && pol_valid[p] && pol_group[p] == r.group_id) begin
                  v.policy_level = pol_level[p];
                  found = 1'b1;
               end
            deny_hit = 1'b0;
            allow_hit = 1'b0;
            for (int i = 0; i < NUM_RULES; i++) begin
               deny_hit |= rule_hits(i, 1'b1, r.group_id, r.is_ipv6,
                                     v.effective_protocol, r.port, addr);
               allow_hit |= rule_hits(i, 1'b0, r.group_id, r.is_ipv6,
                                      v.effective_protocol, r.port, addr);
            end
            if (v.policy_level == cacl_pkg::LEVEL_LOCKED)
               v.deny_cause = cacl_pkg::CAUSE_LOCKED;
            else if (deny_hit) v.deny_cause = cacl_pkg::CAUSE_DENY_HIT;
            else if (v.policy_level == cacl_pkg::LEVEL_DEFAULT && !allow_hit)
               v.deny_cause = cacl_pkg::CAUSE_NO_ALLOW;
            else v.deny_cause = cacl_pkg::CAUSE_NONE;
            v.allowed = (v.deny_cause == cacl_pkg::CAUSE_NONE);
         end
         cacl_pkg::CMD_WR_RULE: begin
            plen = r.prefix_len;
            if (r.is_ipv6 && plen > cacl_pkg::PLEN_V6) plen = cacl_pkg::PLEN_V6;
            if (!r.is_ipv6 && plen > cacl_pkg::PLEN_V4) plen = cacl_pkg::PLEN_V4;
            acl_valid[r.slot] = 1'b1;
            acl_deny[r.slot]  = r.rule_is_deny;
            acl_v6[r.slot]    = r.is_ipv6;
            acl_proto[r.slot] = (r.sock_protocol > cacl_pkg::PROTO_MAX) ? 8'd0 :
                                r.sock_protocol[7:0];
            acl_port[r.slot]  = r.port;
            acl_plen[r.slot]  = plen;
            acl_group[r.slot] = r.group_id;
            acl_addr[r.slot]  = r.is_ipv6 ? {r.addr_high, r.addr_low}
                                          : {96'd0, r.addr_low[31:0]};
         end
         cacl_pkg::CMD_CLR_RULE: acl_valid[r.slot] = 1'b0;
         cacl_pkg::CMD_WR_POLICY: if (r.slot < NUM_POLICIES) begin
            pol_valid[r.slot] = 1'b1;
            pol_level[r.slot] = (r.policy_value > 8'(cacl_pkg::LEVEL_LOCKED)) ?
                                cacl_pkg::LEVEL_LOCKED : r.policy_value[1:0];
            pol_group[r.slot] = r.group_id;
         end
         cacl_pkg::CMD_CLR_POLICY: if (r.slot < NUM_POLICIES) pol_valid[r.slot] = 1'b0;
         default: ;
      endcase
      return v;
   endfunction

   task automatic send_item(cacl_pkg::req_type r);
      cacl_pkg::rsp_type v;
      int gap;
      gap = ($urandom_range(99) < req_idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, r.policy_value, r.rule_is_deny, r.prefix_len, r.addr_low,
                     r.addr_high, r.port, r.sock_type, r.sock_protocol, r.is_ipv6,
                     r.group_id, r.slot, r.command};
      do @(posedge clock); while (!req_tready);
      v = classify(r);
      verdict_q.push_back(v);
      if (r.command == cacl_pkg::CMD_CHECK) begin
         n_checks++;
         if (v.allowed) n_allowed++;
         if (v.deny_cause == cacl_pkg::CAUSE_LOCKED) n_locked++;
         if (v.deny_cause == cacl_pkg::CAUSE_DENY_HIT) n_deny_hit++;
         if (v.deny_cause == cacl_pkg::CAUSE_NO_ALLOW) n_no_allow++;
      end
   endtask

   always @(posedge clock) begin
      cacl_pkg::rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[12:0];
         got.allowed = rsp_tdata[0];
         got.deny_cause = rsp_tdata[2:1];
         got.effective_protocol = rsp_tdata[10:3];
         got.policy_level = rsp_tdata[12:11];
         if (verdict_q.size() == 0) begin
            $error("unexpected result item %h", rsp_tdata);
            errors++;
         end else begin
            want = verdict_q.pop_front();
            if (got.allowed != want.allowed) begin
               $error("allowed: expected %0d actual %0d", want.allowed, got.allowed);
               errors++;
            end
            if (got.deny_cause != want.deny_cause) begin
               $error("deny_cause: expected %0d actual %0d", want.deny_cause,
                      got.deny_cause);
               errors++;
            end
            if (got.effective_protocol != want.effective_protocol) begin
               $error("effective_protocol: expected %0d actual %0d",
                      want.effective_protocol, got.effective_protocol);
               errors++;
            end
            if (got.policy_level != want.policy_level) begin
               $error("policy_level: expected %0d actual %0d", want.policy_level,
                      got.policy_level);
               errors++;
            end
         end
      end
   end

   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("connection_acl_classifier_top_test NOT OK");
         $finish;
      end
   end

   function automatic cacl_pkg::req_type blank_item(logic [2:0] cmd);
      cacl_pkg::req_type r;
      r = '0;
      r.command = cmd;
      return r;
   endfunction

   task automatic test_directed();
      cacl_pkg::req_type r;
      // empty stores: open, protocol fallback
      r = blank_item(cacl_pkg::CMD_CHECK); r.sock_type = cacl_pkg::STYPE_STREAM;
      send_item(r);
      r.sock_type = cacl_pkg::STYPE_DATAGRAM; send_item(r);
      r.sock_type = 4'hF; r.group_id = '1; send_item(r);
      r.sock_protocol = 32'hFFFF_FFFF; send_item(r);
      r.sock_protocol = 32'd255; send_item(r);
      // clamped policy value, then lowest slot wins
      r = blank_item(cacl_pkg::CMD_WR_POLICY); r.slot = 6'd5; r.group_id = '1;
      r.policy_value = 8'hFF; send_item(r);
      r = blank_item(cacl_pkg::CMD_CHECK); r.group_id = '1; send_item(r);
      r = blank_item(cacl_pkg::CMD_WR_POLICY); r.slot = 6'd0; r.group_id = '1;
      r.policy_value = 8'd1; send_item(r);
      r = blank_item(cacl_pkg::CMD_CHECK); r.group_id = '1; r.sock_protocol = 32'd6;
      r.port = 16'hFFFF; r.addr_low = 64'hFFFF_FFFF_C0A8_0101; send_item(r);
      // exact v4 allow rule with oversized prefix and protocol above range
      r = blank_item(cacl_pkg::CMD_WR_RULE); r.slot = 6'd63; r.group_id = '1;
      r.sock_protocol = 32'h100; r.port = 16'hFFFF; r.prefix_len = 8'hFF;
      r.addr_low = 64'hA5A5_A5A5_C0A8_0101; r.addr_high = '1; send_item(r);
      r = blank_item(cacl_pkg::CMD_CHECK); r.group_id = '1; r.sock_protocol = 32'd6;
      r.port = 16'hFFFF; r.addr_low = 64'h0000_0000_C0A8_0101; send_item(r);
      r.addr_low[0] = 1'b1 ^ r.addr_low[0]; send_item(r);
      // v6 deny with zero prefix matches anything of its family
      r = blank_item(cacl_pkg::CMD_WR_RULE); r.slot = 6'd0; r.group_id = '1;
      r.is_ipv6 = 1'b1; r.rule_is_deny = 1'b1; send_item(r);
      r = blank_item(cacl_pkg::CMD_CHECK); r.group_id = '1; r.is_ipv6 = 1'b1;
      r.addr_high = '1; r.addr_low = '1; r.sock_type = cacl_pkg::STYPE_DATAGRAM;
      send_item(r);
      r = blank_item(cacl_pkg::CMD_CLR_RULE); send_item(r);
      r = blank_item(cacl_pkg::CMD_WR_RULE); r.slot = 6'd1; r.group_id = '1;
      r.is_ipv6 = 1'b1; r.prefix_len = 8'd200; r.addr_high = '1; r.addr_low = '1;
      send_item(r);
      r = blank_item(cacl_pkg::CMD_CHECK); r.group_id = '1; r.is_ipv6 = 1'b1;
      r.addr_high = '1; r.addr_low = '1; send_item(r);
      r.addr_low = 64'hFFFF_FFFF_FFFF_FFFE; send_item(r);
      // out of range policy slot, clears, unknown commands
      r = blank_item(cacl_pkg::CMD_WR_POLICY); r.slot = 6'd63; r.policy_value = 8'd2;
      send_item(r);
      r = blank_item(cacl_pkg::CMD_CLR_POLICY); r.slot = 6'd63; send_item(r);
      r.slot = 6'd0; send_item(r);
      r.slot = 6'd5; send_item(r);
      for (int c = int'(cacl_pkg::CMD_CLR_POLICY) + 1; c < 8; c++) begin
         r = '1; r.command = c[2:0]; send_item(r);
      end
      r = blank_item(cacl_pkg::CMD_CHECK); r.group_id = '1; send_item(r);
   endtask

   function automatic cacl_pkg::req_type random_item();
      cacl_pkg::req_type r;
      int k, sel, lo;
      logic [127:0] addr;
      r.command = cacl_pkg::CMD_CHECK; r.slot = 6'($urandom);
      r.group_id = {$urandom, $urandom}; r.is_ipv6 = 1'($urandom);
      r.sock_protocol = $urandom; r.sock_type = 4'($urandom);
      r.port = 16'($urandom); r.addr_high = {$urandom, $urandom};
      r.addr_low = {$urandom, $urandom}; r.prefix_len = 8'($urandom);
      r.rule_is_deny = 1'($urandom); r.policy_value = 8'($urandom);
      sel = $urandom_range(99);
      if (sel < 55) r.command = cacl_pkg::CMD_CHECK;
      else if (sel < 80) r.command = cacl_pkg::CMD_WR_RULE;
      else if (sel < 87) r.command = cacl_pkg::CMD_CLR_RULE;
      else if (sel < 95) r.command = cacl_pkg::CMD_WR_POLICY;
      else if (sel < 98) r.command = cacl_pkg::CMD_CLR_POLICY;
      else r.command = 3'($urandom_range(int'(cacl_pkg::CMD_CLR_POLICY) + 1, 7));
      if ($urandom_range(99) < 12) return r;    // noise
      k = $urandom_range(3);
      r.group_id = grp_pool[k];
      if (r.command == cacl_pkg::CMD_WR_POLICY || r.command == cacl_pkg::CMD_CLR_POLICY)
      begin
         if ($urandom_range(9) != 0) r.slot = 6'($urandom_range(NUM_POLICIES - 1));
         if ($urandom_range(1)) r.policy_value = 8'($urandom_range(3));
         return r;
      end
      if ($urandom_range(1)) begin
         if ($urandom_range(3) == 0) r.sock_protocol = 32'd0;
         else if ($urandom_range(1)) r.sock_protocol = {24'd0, cacl_pkg::PROTO_TCP};
         else r.sock_protocol = {24'd0, cacl_pkg::PROTO_UDP};
      end
      if ($urandom_range(1)) r.sock_type = 4'($urandom_range(3));
      if ($urandom_range(2) != 0) r.port = ($urandom_range(1)) ? 16'd443 :
                                           16'($urandom_range(2) == 0 ? 0 : 80);
      r.prefix_len = 8'($urandom_range(r.is_ipv6 ? 136 : 40));
      addr = addr_pool[$urandom_range(3)];
      lo = $urandom_range(127);
      if ($urandom_range(2) == 0) addr = addr ^ (128'd1 << lo);
      if (!r.is_ipv6) addr[63:32] = 32'($urandom);
      r.addr_high = addr[127:64];
      r.addr_low = addr[63:0];
      return r;
   endfunction

   task automatic test_random(int count, int send_pct, int recv_pct);
      req_idle_pct = send_pct;
      rsp_idle_pct = recv_pct;
      repeat (count) send_item(random_item());
   endtask

   initial begin
      for (int i = 0; i < NUM_RULES; i++) acl_valid[i] = 1'b0;
      for (int i = 0; i < NUM_POLICIES; i++) pol_valid[i] = 1'b0;
      grp_pool[0] = '0; grp_pool[1] = '1;
      grp_pool[2] = {$urandom, $urandom}; grp_pool[3] = {$urandom, $urandom};
      for (int i = 0; i < 4; i++) addr_pool[i] = {$urandom, $urandom, $urandom, $urandom};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(560, 32, 84);
      test_random(560, 84, 32);
      test_random(560, 0, 0);
      req_tvalid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("checks %0d: allowed %0d, locked %0d, deny rule %0d, no allow %0d",
               n_checks, n_allowed, n_locked, n_deny_hit, n_no_allow);
      if (errors == 0)
         $display("connection_acl_classifier_top_test OK");
      else
         $display("connection_acl_classifier_top_test NOT OK");
      $finish;
   end

endmodule
